// ----- design/crcd_pkg.sv -----
// ============================================================================
// crcd_pkg - clock replacement cache directory package
// Widths, configuration register indexes and the structs passed between the
// sequencer and the way cells.
// ============================================================================
`default_nettype none

package crcd_pkg;

    localparam int PAGE_W  = 32;
    localparam int COUNT_W = 32;
    localparam int SLOT_W  = 4;
    localparam int CAP_W   = 5;
    localparam int CFG_W   = 5;
    localparam int CFG_IDX_W = 1;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_POLICY      = 1'd0;
    localparam cfg_idx_t CFG_ACTIVE_WAYS = 1'd1;

    localparam logic [CAP_W-1:0] ACTIVE_WAYS_RESET = 5'd16;

    // commands from the sequencer to one way
    typedef struct packed {
        logic fill;     // load page, set valid and reference, dirty from write flag
        logic touch;    // hit: set reference, set dirty on a write
        logic clr_ref;  // hand passes over this way
        logic tok_we;   // hand token load or move
        logic tok_d;
    } cell_cmd_t;

    // priority chains rippling from way 0 upwards
    typedef struct packed {
        logic hit;
        logic inv;
    } chain_t;

    // per-way status back to the sequencer
    typedef struct packed {
        logic valid;
        logic dirty;
        logic refd;
        logic tok;
        logic hit_sel;
        logic inv_sel;
    } cell_stat_t;

endpackage

`default_nettype wire

// ----- design/crcd_cell.sv -----
// ============================================================================
// crcd_cell - one way of the directory
// Holds tag, valid, dirty and reference bits plus the clock hand token. Does
// its own tag compare and takes part in the first-match and first-free chains.
// ============================================================================
`default_nettype none

module crcd_cell (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [crcd_pkg::PAGE_W-1:0] page,
    input  wire logic                        wr,
    input  wire logic                        in_cap,
    input  wire crcd_pkg::cell_cmd_t         cmd,
    input  wire crcd_pkg::chain_t            chain_in,
    output crcd_pkg::chain_t                 chain_out,
    output crcd_pkg::cell_stat_t             stat
);
    import crcd_pkg::*;

    logic [PAGE_W-1:0] tag_reg;
    logic              valid_reg;
    logic              dirty_reg;
    logic              ref_reg;
    logic              tok_reg;
    logic              match;
    logic              free;

    assign match = valid_reg && in_cap && (tag_reg == page);
    assign free  = !valid_reg && in_cap;

    assign chain_out.hit = chain_in.hit || match;
    assign chain_out.inv = chain_in.inv || free;

    assign stat.valid   = valid_reg;
    assign stat.dirty   = dirty_reg;
    assign stat.refd    = ref_reg;
    assign stat.tok     = tok_reg;
    assign stat.hit_sel = match && !chain_in.hit;
    assign stat.inv_sel = free && !chain_in.inv;

    always_ff @(posedge clk)
    begin
        if (cmd.fill)
        begin
            tag_reg <= page;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            dirty_reg <= 1'b0;
            ref_reg   <= 1'b0;
            tok_reg   <= 1'b0;
        end
        else
        begin
            priority if (cmd.fill)
            begin
                valid_reg <= 1'b1;
                dirty_reg <= wr;
                ref_reg   <= 1'b1;
            end
            else if (cmd.touch)
            begin
                ref_reg <= 1'b1;
                if (wr)
                begin
                    dirty_reg <= 1'b1;
                end
            end
            else if (cmd.clr_ref)
            begin
                ref_reg <= 1'b0;
            end
            if (cmd.tok_we)
            begin
                tok_reg <= cmd.tok_d;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/clock_replacement_cache_directory_core.sv -----
// ============================================================================
// clock_replacement_cache_directory_core - clock page directory
// Fully associative directory of WAYS ways with plain or enhanced clock
// victim choice and saturating hit, miss and access counters.
// ============================================================================
//
//  channel   handshake              payload
//  -------   ---------------------  --------------------------------------------
//  item in   start, busy            page, write_access
//  result    done (one cycle)       hit, evicted, slot, hit_count, miss_count,
//                                   access_count
//  config    cfg_write              cfg_index, cfg_data
//
//  A hit or a fill of a free way goes through ST_LOOKUP and gives a registered done;
//  the next item may start in the done cycle.
//  An eviction adds the hand walk in ST_SCAN: the token moves one way a cycle;
//  enhanced clock walks the clean, dirty, retry and any passes in that order.
//  Reset clears all ways, the hand and the counters; no clearing pass.
//  The receiver takes every result in its done cycle.
// ============================================================================
`default_nettype none

module clock_replacement_cache_directory_core #(
    parameter int WAYS = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [crcd_pkg::PAGE_W-1:0]      page,
    input  wire logic                             write_access,
    output logic                                  done,
    output logic                                  hit,
    output logic                                  evicted,
    output logic [crcd_pkg::SLOT_W-1:0]           slot,
    output logic [crcd_pkg::COUNT_W-1:0]          hit_count,
    output logic [crcd_pkg::COUNT_W-1:0]          miss_count,
    output logic [crcd_pkg::COUNT_W-1:0]          access_count,
    input  wire logic                             cfg_write,
    input  wire crcd_pkg::cfg_idx_t               cfg_index,
    input  wire logic [crcd_pkg::CFG_W-1:0]       cfg_data
);
    import crcd_pkg::*;

    localparam int IDX_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int MAX_CAP = (WAYS < 31) ? WAYS : 31;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN
    } state_t;

    typedef enum logic [2:0] {
        PASS_PLAIN,
        PASS_CLEAN,
        PASS_DIRTY,
        PASS_RETRY,
        PASS_ANY
    } pass_t;

    state_t             state_reg;
    pass_t              pass_reg;
    logic [CAP_W-1:0]   step_reg;
    logic [CAP_W-1:0]   fill_count_reg;
    logic [IDX_W-1:0]   hand_reg;
    logic [PAGE_W-1:0]  page_reg;
    logic               wr_reg;
    logic [COUNT_W-1:0] hits_reg;
    logic [COUNT_W-1:0] misses_reg;
    logic [COUNT_W-1:0] accesses_reg;
    logic               done_reg;
    logic               hit_reg;
    logic               evicted_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic               policy_reg;
    logic [CAP_W-1:0]   active_ways_reg;

    cell_cmd_t  cmd   [WAYS];
    cell_stat_t stat  [WAYS];
    chain_t     chain [WAYS+1];

    logic [WAYS-1:0]  hit_sel_v;
    logic [WAYS-1:0]  inv_sel_v;
    logic [WAYS-1:0]  tok_v;
    logic [WAYS-1:0]  ref_v;
    logic [WAYS-1:0]  dirty_v;
    logic [WAYS-1:0]  valid_v;
    logic [WAYS-1:0]  in_cap_v;
    logic [WAYS-1:0]  last_v;
    logic [WAYS-1:0]  tok_nb;

    logic [CAP_W-1:0] cap;
    logic [CAP_W-1:0] cap_m1;
    logic [IDX_W-1:0] start_idx;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] inv_idx;
    logic [IDX_W-1:0] tok_idx;
    logic [IDX_W-1:0] hand_next;
    logic             hit_any;
    logic             inv_any;
    logic             fill_ok;
    logic             sel_ref;
    logic             sel_dirty;
    logic             sel_valid;
    logic             wrap_tok;
    logic             take;
    logic             last_step;

    assign chain[0] = '0;

    for (genvar g = 0; g < WAYS; g++)
    begin : g_way
        crcd_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .page      (page_reg),
            .wr        (wr_reg),
            .in_cap    (in_cap_v[g]),
            .cmd       (cmd[g]),
            .chain_in  (chain[g]),
            .chain_out (chain[g+1]),
            .stat      (stat[g])
        );

        assign hit_sel_v[g] = stat[g].hit_sel;
        assign inv_sel_v[g] = stat[g].inv_sel;
        assign tok_v[g]     = stat[g].tok;
        assign ref_v[g]     = stat[g].refd;
        assign dirty_v[g]   = stat[g].dirty;
        assign valid_v[g]   = stat[g].valid;
        assign in_cap_v[g]  = (g < int'(cap));
        assign last_v[g]    = (g == int'(cap_m1));
    end

    // capacity: zero acts as one, anything above the way count as the way count
    always_comb
    begin
        if (active_ways_reg == '0)
        begin
            cap = CAP_W'(1);
        end
        else if (int'(active_ways_reg) > WAYS)
        begin
            cap = CAP_W'(MAX_CAP);
        end
        else
        begin
            cap = active_ways_reg;
        end
    end

    assign cap_m1    = cap - CAP_W'(1);
    assign start_idx = (int'(hand_reg) < int'(cap)) ? hand_reg : '0;
    assign hit_any   = chain[WAYS].hit;
    assign inv_any   = chain[WAYS].inv;
    assign fill_ok   = !hit_any && (fill_count_reg < cap) && inv_any;
    assign sel_ref   = |(tok_v & ref_v);
    assign sel_dirty = |(tok_v & dirty_v);
    assign sel_valid = |(tok_v & valid_v);
    assign wrap_tok  = |(tok_v & last_v);
    // token moves to the next way in use, wrapping at the last one
    assign tok_nb    = ((tok_v & ~last_v) << 1) | WAYS'(wrap_tok);
    assign last_step = (step_reg == cap_m1);
    assign hand_next = (int'(tok_idx) == int'(cap_m1)) ? '0 : tok_idx + IDX_W'(1);

    always_comb
    begin
        hit_idx = '0;
        inv_idx = '0;
        tok_idx = '0;
        for (int i = 0; i < WAYS; i++)
        begin
            if (hit_sel_v[i])
            begin
                hit_idx = hit_idx | IDX_W'(i);
            end
            if (inv_sel_v[i])
            begin
                inv_idx = inv_idx | IDX_W'(i);
            end
            if (tok_v[i])
            begin
                tok_idx = tok_idx | IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        unique case (pass_reg)
            PASS_PLAIN: take = !sel_ref;
            PASS_CLEAN: take = !sel_ref && !sel_dirty;
            PASS_DIRTY: take = !sel_ref && sel_dirty;
            PASS_RETRY: take = !sel_ref && !sel_dirty;
            PASS_ANY:   take = 1'b1;
            default:    take = 1'b1;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            cmd[i] = '0;
            unique case (state_reg)
                ST_LOOKUP:
                begin
                    cmd[i].touch  = hit_any && hit_sel_v[i];
                    cmd[i].fill   = fill_ok && inv_sel_v[i];
                    cmd[i].tok_we = !hit_any && !fill_ok;
                    cmd[i].tok_d  = (i == int'(start_idx));
                end
                ST_SCAN:
                begin
                    if (take)
                    begin
                        cmd[i].fill = tok_v[i];
                    end
                    else
                    begin
                        cmd[i].clr_ref = tok_v[i] &&
                                         (pass_reg == PASS_PLAIN || pass_reg == PASS_DIRTY);
                        cmd[i].tok_we  = 1'b1;
                        cmd[i].tok_d   = tok_nb[i];
                    end
                end
                default:
                begin
                    cmd[i] = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg      <= 1'b0;
            active_ways_reg <= ACTIVE_WAYS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_POLICY:      policy_reg      <= cfg_data[0];
                CFG_ACTIVE_WAYS: active_ways_reg <= cfg_data;
                default:         policy_reg      <= policy_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pass_reg       <= PASS_PLAIN;
            step_reg       <= '0;
            fill_count_reg <= '0;
            hand_reg       <= '0;
            page_reg       <= '0;
            wr_reg         <= 1'b0;
            hits_reg       <= '0;
            misses_reg     <= '0;
            accesses_reg   <= '0;
            done_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            evicted_reg    <= 1'b0;
            slot_reg       <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        page_reg  <= page;
                        wr_reg    <= write_access;
                        state_reg <= ST_LOOKUP;
                    end
                end
                ST_LOOKUP:
                begin
                    if (accesses_reg != '1)
                    begin
                        accesses_reg <= accesses_reg + COUNT_W'(1);
                    end
                    if (hit_any)
                    begin
                        if (hits_reg != '1)
                        begin
                            hits_reg <= hits_reg + COUNT_W'(1);
                        end
                        hit_reg     <= 1'b1;
                        evicted_reg <= 1'b0;
                        slot_reg    <= SLOT_W'(hit_idx);
                        done_reg    <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                    else
                    begin
                        if (misses_reg != '1)
                        begin
                            misses_reg <= misses_reg + COUNT_W'(1);
                        end
                        if (fill_ok)
                        begin
                            fill_count_reg <= fill_count_reg + CAP_W'(1);
                            hit_reg        <= 1'b0;
                            evicted_reg    <= 1'b0;
                            slot_reg       <= SLOT_W'(inv_idx);
                            done_reg       <= 1'b1;
                            state_reg      <= ST_IDLE;
                        end
                        else
                        begin
                            pass_reg  <= policy_reg ? PASS_CLEAN : PASS_PLAIN;
                            step_reg  <= '0;
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (take)
                    begin
                        hit_reg     <= 1'b0;
                        evicted_reg <= sel_valid;
                        slot_reg    <= SLOT_W'(tok_idx);
                        hand_reg    <= hand_next;
                        done_reg    <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                    else if (last_step)
                    begin
                        // a full turn of the hand without a victim: next class (enhanced clock only)
                        step_reg <= '0;
                        unique case (pass_reg)
                            PASS_CLEAN: pass_reg <= PASS_DIRTY;
                            PASS_DIRTY: pass_reg <= PASS_RETRY;
                            PASS_RETRY: pass_reg <= PASS_ANY;
                            default:    pass_reg <= pass_reg;
                        endcase
                    end
                    else
                    begin
                        step_reg <= step_reg + CAP_W'(1);
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign hit          = hit_reg;
    assign evicted      = evicted_reg;
    assign slot         = slot_reg;
    assign hit_count    = hits_reg;
    assign miss_count   = misses_reg;
    assign access_count = accesses_reg;

endmodule

`default_nettype wire
